/* rtl/pcrm_pkg.sv */
// ----------------------------------------------------------------------------
// pcrm_pkg - shared types and constants
// Field widths, register indexes and the request/response bundle that links
// the rate meter control to its bit-serial rate divider.
// ----------------------------------------------------------------------------
package pcrm_pkg;

    localparam int unsigned CNT_W      = 32;   // piece count width
    localparam int unsigned TIME_W     = 32;   // millisecond time stamp width
    localparam int unsigned RATE_W     = 24;   // Q16.8 rate width
    localparam int unsigned CFG_W      = 16;   // widest config register
    localparam int unsigned SHIFT_W    = 3;    // smooth_shift width
    localparam int unsigned SCALE_W    = 10;   // bits of the ms-to-s factor
    localparam int unsigned RATE_SCALE = 1000; // ms per second
    localparam int unsigned CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_REF = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_REF = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHIFT   = 2'd3;

    localparam logic [CFG_W-1:0]   WINDOW_RST  = 16'd1000;
    localparam logic [CFG_W-1:0]   MIN_REF_RST = 16'd30;
    localparam logic [CFG_W-1:0]   MAX_REF_RST = 16'd1000;
    localparam logic [SHIFT_W-1:0] SHIFT_RST   = 3'd1;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] ms;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quo;
    } t_div_rsp;

endpackage

/* rtl/pcrm_div.sv */
// ----------------------------------------------------------------------------
// pcrm_div - bit-serial rate divider
// Computes floor(1000 * count * 2^FRAC_BITS / ms), saturated to the rate
// width, 0 when ms is 0. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcrm_div #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcrm_pkg::t_div_req i_req,
    output pcrm_pkg::t_div_rsp o_rsp
);
    import pcrm_pkg::*;

    localparam int unsigned PW    = CNT_W + SCALE_W;
    localparam int unsigned NW    = PW + FRAC_BITS;
    localparam int unsigned BIT_W = $clog2(RATE_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_LOAD,
        D_RUN
    } t_dstate;

    t_dstate           r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [TIME_W-1:0] r_ms;
    logic [PW-1:0]     r_prod;
    logic [TIME_W-1:0] r_rem;
    logic [RATE_W-1:0] r_low;
    logic [RATE_W-1:0] r_q;
    logic [BIT_W-1:0]  r_bit;
    logic              r_done;

    logic [NW-1:0]     w_num;
    logic              w_sat;
    logic [TIME_W:0]   w_trial;
    logic              w_ge;

    assign w_num   = NW'(r_prod) << FRAC_BITS;
    // quotient needs more than RATE_W bits when num >> RATE_W reaches ms
    assign w_sat   = NW'(w_num >> RATE_W) >= NW'(r_ms);
    assign w_trial = {r_rem, r_low[RATE_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            // one-cycle pulse: early exit at load or last quotient bit
            r_done <= ((r_state == D_LOAD) && ((r_ms == '0) || w_sat))
                      || ((r_state == D_RUN) && (r_bit == '0));
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_cnt   <= i_req.count;
                        r_ms    <= i_req.ms;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_prod  <= PW'(r_cnt) * PW'(RATE_SCALE);
                    r_state <= D_LOAD;
                end
                D_LOAD: begin
                    r_rem <= TIME_W'(w_num >> RATE_W);
                    r_low <= w_num[RATE_W-1:0];
                    r_bit <= BIT_W'(RATE_W - 1);
                    if (r_ms == '0) begin
                        r_q     <= '0;
                        r_state <= D_IDLE;
                    end else if (w_sat) begin
                        r_q     <= '1;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    // remainder stays below ms, so it fits TIME_W bits
                    r_rem <= w_ge ? TIME_W'(w_trial - {1'b0, r_ms})
                                  : w_trial[TIME_W-1:0];
                    r_low <= r_low << 1;
                    r_q   <= {r_q[RATE_W-2:0], w_ge};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

/* rtl/pulse_counter_rate_meter.sv */
// ----------------------------------------------------------------------------
// pulse_counter_rate_meter - pulse counter with gated-window rate meter
// Counts rising edges of a sampled pin, measures the rate per window, smooths
// it, and reports count and rates under refresh gating.
// ----------------------------------------------------------------------------
// Each sample is registered, checked for a window close (window division and
// smoothing filter), then checked for a due report (average division and
// output register, which can stall). A new sample is taken only when idle,
// after the previous one is through; the bit-serial divider is shared.
// Reset: synchronous, active low; counters, window and report state clear,
// config registers return to their defaults.
module pulse_counter_rate_meter #(
    parameter int unsigned RATE_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // pin_level, now_ms, pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // piece_total, average_rate, window_rate, filtered_rate
    output logic [103:0]                    m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [pcrm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pcrm_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import pcrm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_WDIV,
        S_FILT1,
        S_FILT2,
        S_DEC,
        S_ADIV,
        S_OUT
    } t_state;

    t_state             r_state;

    logic [CFG_W-1:0]   r_window;
    logic [CFG_W-1:0]   r_min_ref;
    logic [CFG_W-1:0]   r_max_ref;
    logic [SHIFT_W-1:0] r_shift;

    logic               r_prev;
    logic [CNT_W-1:0]   r_count;
    logic [TIME_W-1:0]  r_wst_time;
    logic [CNT_W-1:0]   r_wst_total;
    logic [RATE_W-1:0]  r_recent;
    logic [RATE_W-1:0]  r_smooth;
    logic [TIME_W-1:0]  r_last_time;
    logic [CNT_W-1:0]   r_last_total;
    logic               r_reported;

    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_elapsed;
    logic [TIME_W-1:0]  r_gap;
    logic signed [RATE_W:0] r_diff;

    t_div_req           r_req;
    t_div_rsp           w_rsp;

    logic               w_in_pin;
    logic [TIME_W-1:0]  w_in_now;
    logic               w_skip;
    logic signed [RATE_W:0] w_step;

    assign w_in_pin = s_axis_tdata[0];
    assign w_in_now = s_axis_tdata[TIME_W:1];

    assign s_axis_tready = (r_state == S_IDLE);

    assign w_step = r_diff >>> r_shift;

    // forced report and first report override suppression
    assign w_skip = ((r_gap < TIME_W'(r_min_ref)) || (r_count == r_last_total))
                    && !(r_gap > TIME_W'(r_max_ref)) && r_reported;

    pcrm_div #(
        .FRAC_BITS (RATE_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= WINDOW_RST;
            r_min_ref <= MIN_REF_RST;
            r_max_ref <= MAX_REF_RST;
            r_shift   <= SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WINDOW:  r_window  <= i_cfg_wdata;
                CFG_MIN_REF: r_min_ref <= i_cfg_wdata;
                CFG_MAX_REF: r_max_ref <= i_cfg_wdata;
                CFG_SHIFT:   r_shift   <= i_cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev        <= 1'b0;
            r_count       <= '0;
            r_wst_time    <= '0;
            r_wst_total   <= '0;
            r_recent      <= '0;
            r_smooth      <= '0;
            r_last_time   <= '0;
            r_last_total  <= '0;
            r_reported    <= 1'b0;
            r_req.start   <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            // divider start pulse: window close or report due
            r_req.start <= ((r_state == S_WIN) && (r_elapsed > TIME_W'(r_window)))
                           || ((r_state == S_DEC) && !w_skip);
            if ((r_state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_prev    <= w_in_pin;
                        if (w_in_pin && !r_prev) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_now     <= w_in_now;
                        r_elapsed <= w_in_now - r_wst_time;
                        r_gap     <= w_in_now - r_last_time;
                        r_state   <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (r_elapsed > TIME_W'(r_window)) begin
                        r_req.count <= r_count - r_wst_total;
                        r_req.ms    <= r_elapsed;
                        r_wst_time  <= r_wst_time + TIME_W'(r_window);
                        r_wst_total <= r_count;
                        r_state     <= S_WDIV;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_WDIV: begin
                    if (w_rsp.done) begin
                        r_recent <= w_rsp.quo;
                        r_state  <= S_FILT1;
                    end
                end
                S_FILT1: begin
                    r_diff  <= {1'b0, r_recent} - {1'b0, r_smooth};
                    r_state <= S_FILT2;
                end
                S_FILT2: begin
                    // arithmetic shift floors negative steps
                    r_smooth <= r_smooth + w_step[RATE_W-1:0];
                    r_state  <= S_DEC;
                end
                S_DEC: begin
                    if (w_skip) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last_time  <= r_now;
                        r_last_total <= r_count;
                        r_reported   <= 1'b1;
                        r_req.count  <= r_count;
                        r_req.ms     <= r_now;
                        r_state      <= S_ADIV;
                    end
                end
                S_ADIV: begin
                    if (w_rsp.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // divider holds its quotient until the next request
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tdata  <= {r_smooth, r_recent, w_rsp.quo, r_count};
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WDIV) || (r_state == S_ADIV))
        else $error("divider finished with no division pending");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sample taken while previous beat still in work");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_OUT)
        else $error("report raised outside the output step");

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req.start |=> (r_state == S_WDIV) || (r_state == S_ADIV))
        else $error("division requested without waiting for it");

endmodule
